// ===== rtl/frq_pkg.sv =====
// shared types and constants of the frame ring queue
`default_nettype none

package frq_pkg;

	localparam int DATA_W        = 8;
	localparam int KIND_W        = 3;
	localparam int OCC_W         = 4;
	localparam int DROP_W        = 32;
	localparam int S_TDATA_W     = 8;
	localparam int M_TDATA_USED  = DATA_W + OCC_W + 1 + DROP_W;
	localparam int M_TDATA_W     = ((M_TDATA_USED + 7) / 8) * 8;
	localparam int SLOTS_DEF     = 8;
	localparam int MAX_FRAME_DEF = 64;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_PUSH_END,
		OP_POP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] data;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACCEPT    = 3'd0,
		KIND_LONG      = 3'd1,
		KIND_DROP      = 3'd2,
		KIND_POP_BYTE  = 3'd3,
		KIND_POP_EMPTY = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		FATE_ACCEPT = 2'd0,
		FATE_LONG   = 2'd1,
		FATE_DROP   = 2'd2
	} fate_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEN,
		ST_POP
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/frq_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module frq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/frq_front.sv =====
// input side: accepts requests, classifies them and queues them for the back end
`default_nettype none

module frq_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [frq_pkg::S_TDATA_W-1:0]  s_tdata,
	input  wire logic                           s_tuser,
	input  wire logic                           s_tlast,
	output frq_pkg::head_t                      head,
	input  wire logic                           deq
);

	localparam int DEPTH = 2;
	localparam int PTR_W = 1;

	frq_pkg::item_t   q_item_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;
	frq_pkg::item_t   in_item;
	logic             push_en;
	logic             pop_en;

	always_comb begin
		in_item.data = s_tdata;
		if (s_tuser) begin
			in_item.op = frq_pkg::OP_POP;
		end else if (s_tlast) begin
			in_item.op = frq_pkg::OP_PUSH_END;
		end else begin
			in_item.op = frq_pkg::OP_PUSH;
		end
	end

	assign s_tready   = (fill_q != (PTR_W+1)'(DEPTH));
	assign push_en    = s_tvalid && s_tready;
	assign head.valid = (fill_q != '0);
	assign head.item  = q_item_q[rd_ptr_q];
	assign pop_en     = deq && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push_en, pop_en})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			q_item_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/frq_back.sv =====
// back end: frame store, slot pointers, drop counter and result register
`default_nettype none

module frq_back #(
	parameter int SLOTS     = frq_pkg::SLOTS_DEF,
	parameter int MAX_FRAME = frq_pkg::MAX_FRAME_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire frq_pkg::head_t                 head,
	output logic                                deq,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [frq_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic [frq_pkg::KIND_W-1:0]          m_tuser,
	output logic                                m_tlast
);

	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int IDX_W       = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam int CNT_W       = $clog2(MAX_FRAME + 2);
	localparam int LEN_W       = $clog2(MAX_FRAME + 1);
	localparam int FRAME_DEPTH = SLOTS * (2 ** IDX_W);
	localparam int FA_W        = SLOT_W + IDX_W;
	localparam int OCCI_W      = SLOT_W + 1;
	localparam int PAD_W       = frq_pkg::M_TDATA_W - frq_pkg::M_TDATA_USED;

	localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_FRAME);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
	localparam logic [OCCI_W-1:0] SLOTS_OCC = OCCI_W'(SLOTS);

	frq_pkg::state_t               state_q, state_d;
	logic [SLOT_W-1:0]             read_slot_q, read_slot_d;
	logic [SLOT_W-1:0]             write_slot_q, write_slot_d;
	logic                          full_q, full_d;
	logic [frq_pkg::DROP_W-1:0]    drops_q, drops_d;
	logic [CNT_W-1:0]              count_q, count_d;
	frq_pkg::fate_t                fate_q, fate_d;
	logic [SLOT_W-1:0]             pop_slot_q, pop_slot_d;
	logic [LEN_W-1:0]              len_q, len_d;
	logic [IDX_W-1:0]              rd_idx_q, rd_idx_d;
	logic                          pend_last_q, pend_last_d;

	logic                          m_tvalid_q;
	frq_pkg::kind_t                m_kind_q;
	logic                          m_last_q;
	logic [frq_pkg::DATA_W-1:0]    m_byte_q;
	logic [frq_pkg::OCC_W-1:0]     m_occ_q;
	logic                          m_full_q;
	logic [frq_pkg::DROP_W-1:0]    m_drops_q;

	logic                          out_load;
	frq_pkg::kind_t                out_kind;
	logic [frq_pkg::DATA_W-1:0]    out_byte;
	logic                          out_last;
	logic                          out_free;
	logic [OCCI_W-1:0]             occ_d;

	frq_pkg::fate_t                fate0;
	frq_pkg::fate_t                fate1;
	logic                          store_ok;
	logic [CNT_W-1:0]              cnt_inc;
	logic                          empty;
	logic [SLOT_W-1:0]             write_slot_inc;
	logic [SLOT_W-1:0]             read_slot_inc;

	logic                          fs_wr_en;
	logic [FA_W-1:0]               fs_wr_addr;
	logic                          fs_rd_en;
	logic [FA_W-1:0]               fs_rd_addr;
	logic [frq_pkg::DATA_W-1:0]    fs_rd_data;
	logic                          ln_wr_en;
	logic                          ln_rd_en;
	logic [LEN_W-1:0]              ln_rd_data;

	frq_ram #(
		.WIDTH (frq_pkg::DATA_W),
		.DEPTH (FRAME_DEPTH)
	) u_frame_ram (
		.clk     (clk),
		.wr_en   (fs_wr_en),
		.wr_addr (fs_wr_addr),
		.wr_data (head.item.data),
		.rd_en   (fs_rd_en),
		.rd_addr (fs_rd_addr),
		.rd_data (fs_rd_data)
	);

	frq_ram #(
		.WIDTH (LEN_W),
		.DEPTH (SLOTS)
	) u_len_ram (
		.clk     (clk),
		.wr_en   (ln_wr_en),
		.wr_addr (write_slot_q),
		.wr_data (cnt_inc[LEN_W-1:0]),
		.rd_en   (ln_rd_en),
		.rd_addr (read_slot_q),
		.rd_data (ln_rd_data)
	);

	// frame fate is fixed by the first byte, too long wins
	assign fate0    = (count_q == '0)
	                  ? (full_q ? frq_pkg::FATE_DROP : frq_pkg::FATE_ACCEPT) : fate_q;
	assign store_ok = (fate0 == frq_pkg::FATE_ACCEPT) && (count_q < MAX_CNT);
	assign cnt_inc  = (count_q <= MAX_CNT) ? count_q + 1'b1 : count_q;
	assign fate1    = (cnt_inc > MAX_CNT) ? frq_pkg::FATE_LONG : fate0;

	assign empty          = !full_q && (read_slot_q == write_slot_q);
	assign write_slot_inc = (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + 1'b1;
	assign read_slot_inc  = (read_slot_q == LAST_SLOT) ? '0 : read_slot_q + 1'b1;
	assign out_free       = !m_tvalid_q || m_tready;
	assign fs_wr_addr     = {write_slot_q, count_q[IDX_W-1:0]};

	always_comb begin
		state_d      = state_q;
		read_slot_d  = read_slot_q;
		write_slot_d = write_slot_q;
		full_d       = full_q;
		drops_d      = drops_q;
		count_d      = count_q;
		fate_d       = fate_q;
		pop_slot_d   = pop_slot_q;
		len_d        = len_q;
		rd_idx_d     = rd_idx_q;
		pend_last_d  = pend_last_q;
		deq          = 1'b0;
		out_load     = 1'b0;
		out_kind     = frq_pkg::KIND_ACCEPT;
		out_byte     = '0;
		out_last     = 1'b1;
		fs_wr_en     = 1'b0;
		fs_rd_en     = 1'b0;
		fs_rd_addr   = {read_slot_q, {IDX_W{1'b0}}};
		ln_wr_en     = 1'b0;
		ln_rd_en     = 1'b0;

		unique case (state_q)
			frq_pkg::ST_IDLE: begin
				if (head.valid) begin
					unique case (head.item.op)
						frq_pkg::OP_PUSH: begin
							deq      = 1'b1;
							fs_wr_en = store_ok;
							count_d  = cnt_inc;
							fate_d   = fate1;
						end
						frq_pkg::OP_PUSH_END: begin
							if (out_free) begin
								deq      = 1'b1;
								fs_wr_en = store_ok;
								count_d  = '0;
								fate_d   = frq_pkg::FATE_ACCEPT;
								out_load = 1'b1;
								case (fate1)
									frq_pkg::FATE_LONG: begin
										out_kind = frq_pkg::KIND_LONG;
									end
									frq_pkg::FATE_DROP: begin
										drops_d  = drops_q + 1'b1;
										out_kind = frq_pkg::KIND_DROP;
									end
									default: begin
										ln_wr_en     = 1'b1;
										write_slot_d = write_slot_inc;
										if (write_slot_inc == read_slot_q) begin
											full_d = 1'b1;
										end
										out_kind = frq_pkg::KIND_ACCEPT;
									end
								endcase
							end
						end
						frq_pkg::OP_POP: begin
							if (empty) begin
								if (out_free) begin
									deq      = 1'b1;
									out_load = 1'b1;
									out_kind = frq_pkg::KIND_POP_EMPTY;
								end
							end else begin
								deq      = 1'b1;
								ln_rd_en = 1'b1;
								state_d  = frq_pkg::ST_LEN;
							end
						end
						default: begin
							deq = 1'b1;
						end
					endcase
				end
			end
			frq_pkg::ST_LEN: begin
				fs_rd_en    = 1'b1;
				len_d       = ln_rd_data;
				pop_slot_d  = read_slot_q;
				rd_idx_d    = IDX_W'(1);
				pend_last_d = (ln_rd_data <= LEN_W'(1));
				read_slot_d = read_slot_inc;
				full_d      = 1'b0;
				state_d     = frq_pkg::ST_POP;
			end
			frq_pkg::ST_POP: begin
				if (out_free) begin
					out_load = 1'b1;
					out_kind = frq_pkg::KIND_POP_BYTE;
					out_byte = fs_rd_data;
					out_last = pend_last_q;
					if (pend_last_q) begin
						state_d = frq_pkg::ST_IDLE;
					end else begin
						fs_rd_en    = 1'b1;
						fs_rd_addr  = {pop_slot_q, rd_idx_q};
						rd_idx_d    = rd_idx_q + 1'b1;
						pend_last_d = (CNT_W'(rd_idx_q) + CNT_W'(1)) >= CNT_W'(len_q);
					end
				end
			end
			default: begin
				state_d = frq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (full_d) begin
			occ_d = SLOTS_OCC;
		end else if (write_slot_d >= read_slot_d) begin
			occ_d = OCCI_W'(write_slot_d) - OCCI_W'(read_slot_d);
		end else begin
			occ_d = SLOTS_OCC - OCCI_W'(read_slot_d) + OCCI_W'(write_slot_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= frq_pkg::ST_IDLE;
			read_slot_q  <= '0;
			write_slot_q <= '0;
			full_q       <= 1'b0;
			drops_q      <= '0;
			count_q      <= '0;
			fate_q       <= frq_pkg::FATE_ACCEPT;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			read_slot_q  <= read_slot_d;
			write_slot_q <= write_slot_d;
			full_q       <= full_d;
			drops_q      <= drops_d;
			count_q      <= count_d;
			fate_q       <= fate_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pop_slot_q  <= pop_slot_d;
		len_q       <= len_d;
		rd_idx_q    <= rd_idx_d;
		pend_last_q <= pend_last_d;
		if (out_load) begin
			m_kind_q  <= out_kind;
			m_last_q  <= out_last;
			m_byte_q  <= out_byte;
			m_occ_q   <= frq_pkg::OCC_W'(occ_d);
			m_full_q  <= full_d;
			m_drops_q <= drops_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{PAD_W{1'b0}}, m_drops_q, m_full_q, m_occ_q, m_byte_q};

endmodule

`default_nettype wire

// ===== rtl/frame_ring_queue_with_drop_count_top.sv =====
// top level of the frame ring queue with drop counter
//
// channel   dir  tdata                                   tuser    tlast
// s_*       in   [7:0] data_byte                         action   frame_end
// m_*       out  [7:0] out_byte [11:8] occupancy         kind     last_of_run
//                [12] is_full [44:13] drop_count
//
// a stored push byte is written to the frame store as it is dequeued; a pop first reads the
// frame length from the length store, then loads the frame's bytes from the frame store read port
// a two-entry queue sits between input and back end, so input stalls only when it fills
// m_tready low holds the result register; the back end waits only when it has a result
// to load, mid-frame push bytes go on
// asynchronous reset clears pointers, full flag, drop count and open frame;
// frame store and length store are undefined until written
`default_nettype none

module frame_ring_queue_with_drop_count_top #(
	parameter int SLOTS     = frq_pkg::SLOTS_DEF,
	parameter int MAX_FRAME = frq_pkg::MAX_FRAME_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [frq_pkg::S_TDATA_W-1:0]  s_tdata,  // data_byte
	input  wire logic                           s_tuser,  // action
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [frq_pkg::M_TDATA_W-1:0]       m_tdata,  // out_byte, occupancy, is_full, drop_count
	output logic [frq_pkg::KIND_W-1:0]          m_tuser,  // kind
	output logic                                m_tlast
);

	frq_pkg::head_t head;
	logic           deq;

	frq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.head     (head),
		.deq      (deq)
	);

	frq_back #(
		.SLOTS     (SLOTS),
		.MAX_FRAME (MAX_FRAME)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.deq      (deq),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> m_tdata[11:8] == (frq_pkg::OCC_W)'(SLOTS))
	else $error("full flag with occupancy other than slot count");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != frq_pkg::KIND_POP_BYTE) |-> m_tdata[7:0] == 8'd0)
	else $error("byte field set on a non-byte result");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != frq_pkg::KIND_POP_BYTE) |-> m_tlast)
	else $error("single result without last marker");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready
		|=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	else $error("result changed while waiting");

endmodule

`default_nettype wire

// ===== test/frame_ring_queue_with_drop_count_top_test.sv =====
// self-checking testbench of the frame ring queue: frame pushes and pops against a predictor
`default_nettype none

module frame_ring_queue_with_drop_count_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS      = frq_pkg::SLOTS_DEF;
	localparam int MAX_FRAME  = frq_pkg::MAX_FRAME_DEF;
	localparam bit ACT_PUSH   = 1'b0;
	localparam bit ACT_POP    = 1'b1;
	localparam int RAND_ITEMS = 200;
	localparam int HOLD_AT    = 200;
	localparam int HOLD_LEN   = 300;
	localparam int LIMIT      = 400000;

	typedef struct {
		bit       pop;
		bit [7:0] data;
		bit       fend;
	} request_t;

	typedef struct {
		frq_pkg::kind_t kind;
		bit [7:0]       data;
		bit             last;
		bit [3:0]       occ;
		bit             full;
		bit [31:0]      drops;
	} result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [frq_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                          s_tuser = 1'b0;
	logic                          s_tlast = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [frq_pkg::M_TDATA_W-1:0] m_tdata;
	logic [frq_pkg::KIND_W-1:0]    m_tuser;
	logic                          m_tlast;

	frame_ring_queue_with_drop_count_top #(
		.SLOTS     (SLOTS),
		.MAX_FRAME (MAX_FRAME)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// queue model state
	bit [7:0]       frame_mem [SLOTS][MAX_FRAME];
	int             frame_len [SLOTS];
	int             head_slot;
	int             tail_slot;
	bit             q_full;
	bit [31:0]      drop_total;
	int             open_count;
	frq_pkg::fate_t open_fate;

	request_t  pending [$];
	result_t   expected [$];
	int        kind_seen [5];
	int        errors;
	int        n_requests;
	int        n_checked;
	int        cycles;
	bit        tail_phase;
	int        tx_gap;
	request_t  tx_req;
	request_t  acc_req;
	int        rx_gap;
	int        rx_cycles;
	int        hold_left;
	result_t   got;
	result_t   want;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic result_t make_result(frq_pkg::kind_t kind, bit [7:0] data, bit last);
		result_t r;
		r.kind  = kind;
		r.data  = data;
		r.last  = last;
		r.occ   = '0;
		r.full  = 1'b0;
		r.drops = '0;
		return r;
	endfunction

	task automatic queue_step(input request_t req);
		result_t res [$];
		int      len;
		if (req.pop == ACT_PUSH) begin
			if (open_count == 0)
				open_fate = q_full ? frq_pkg::FATE_DROP : frq_pkg::FATE_ACCEPT;
			if (open_fate == frq_pkg::FATE_ACCEPT && open_count < MAX_FRAME)
				frame_mem[tail_slot][open_count] = req.data;
			if (open_count < MAX_FRAME + 1)
				open_count++;
			if (open_count > MAX_FRAME)
				open_fate = frq_pkg::FATE_LONG;
			if (req.fend) begin
				case (open_fate)
					frq_pkg::FATE_LONG: begin
						res.push_back(make_result(frq_pkg::KIND_LONG, 8'h00, 1'b1));
					end
					frq_pkg::FATE_DROP: begin
						drop_total++;
						res.push_back(make_result(frq_pkg::KIND_DROP, 8'h00, 1'b1));
					end
					default: begin
						frame_len[tail_slot] = open_count;
						tail_slot = (tail_slot + 1) % SLOTS;
						if (tail_slot == head_slot)
							q_full = 1'b1;
						res.push_back(make_result(frq_pkg::KIND_ACCEPT, 8'h00, 1'b1));
					end
				endcase
				open_count = 0;
				open_fate  = frq_pkg::FATE_ACCEPT;
			end
		end else begin
			if (!q_full && head_slot == tail_slot) begin
				res.push_back(make_result(frq_pkg::KIND_POP_EMPTY, 8'h00, 1'b1));
			end else begin
				len = (frame_len[head_slot] > MAX_FRAME) ? MAX_FRAME : frame_len[head_slot];
				for (int i = 0; i < len; i++)
					res.push_back(make_result(frq_pkg::KIND_POP_BYTE,
						frame_mem[head_slot][i], i + 1 == len));
				head_slot = (head_slot + 1) % SLOTS;
				q_full = 1'b0;
				if (res.size() == 0)
					res.push_back(make_result(frq_pkg::KIND_POP_EMPTY, 8'h00, 1'b1));
			end
		end
		foreach (res[k]) begin
			res[k].occ   = 4'(q_full ? SLOTS : (tail_slot - head_slot + SLOTS) % SLOTS);
			res[k].full  = q_full;
			res[k].drops = drop_total;
			kind_seen[res[k].kind]++;
			expected.push_back(res[k]);
		end
	endtask

	task automatic add_request(bit pop, bit [7:0] data, bit fend);
		request_t r;
		r.pop  = pop;
		r.data = data;
		r.fend = fend;
		pending.push_back(r);
	endtask

	task automatic add_frame(int len, int mid_pop_pct);
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 99) < mid_pop_pct)
				add_request(ACT_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			add_request(ACT_PUSH, 8'($urandom_range(0, 255)), i == len - 1);
		end
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return MAX_FRAME;
		if (r < 10)
			return MAX_FRAME + 1 + $urandom_range(0, 4);
		if (r < 22)
			return $urandom_range(7, 40);
		return $urandom_range(1, 6);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= 1'b0;
			s_tlast    <= 1'b0;
			tail_phase <= 1'b0;
			tx_gap     = 0;
		end else begin
			tail_phase <= pending.size() < 40;
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending.size() > 0 && !tail_phase && $urandom_range(0, 7) == 0) begin
					tx_gap = $urandom_range(0, 9);
					s_tvalid <= 1'b0;
				end else if (pending.size() > 0) begin
					tx_req = pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= tx_req.data;
					s_tuser  <= tx_req.pop;
					s_tlast  <= tx_req.fend;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			rx_gap    = 0;
			rx_cycles = 0;
			hold_left = 0;
		end else begin
			rx_cycles++;
			if (rx_cycles == HOLD_AT)
				hold_left = HOLD_LEN;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor: check results, then predict accepted requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.kind  = frq_pkg::kind_t'(m_tuser);
				got.data  = m_tdata[7:0];
				got.occ   = m_tdata[11:8];
				got.full  = m_tdata[12];
				got.drops = m_tdata[44:13];
				got.last  = m_tlast;
				n_checked++;
				if (expected.size() == 0) begin
					$error("unexpected result: kind %0d out_byte %0d", m_tuser, got.data);
					errors++;
				end else begin
					want = expected.pop_front();
					if (got.kind != want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, got.kind);
						errors++;
					end
					if (got.data != want.data) begin
						$error("out_byte: expected %0d, got %0d", want.data, got.data);
						errors++;
					end
					if (got.last != want.last) begin
						$error("last_of_run: expected %0d, got %0d", want.last, got.last);
						errors++;
					end
					if (got.occ != want.occ) begin
						$error("occupancy: expected %0d, got %0d", want.occ, got.occ);
						errors++;
					end
					if (got.full != want.full) begin
						$error("is_full: expected %0d, got %0d", want.full, got.full);
						errors++;
					end
					if (got.drops != want.drops) begin
						$error("drop_count: expected %0d, got %0d", want.drops, got.drops);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				acc_req.pop  = s_tuser;
				acc_req.data = s_tdata;
				acc_req.fend = s_tlast;
				n_requests++;
				queue_step(acc_req);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int target;
		int pop_pct;
		head_slot  = 0;
		tail_slot  = 0;
		q_full     = 1'b0;
		drop_total = '0;
		open_count = 0;
		open_fate  = frq_pkg::FATE_ACCEPT;
		errors     = 0;
		n_requests = 0;
		n_checked  = 0;
		cycles     = 0;

		// pop on empty, short frames with extreme bytes
		add_request(ACT_POP, 8'hff, 1'b1);
		add_request(ACT_PUSH, 8'h00, 1'b1);
		add_request(ACT_PUSH, 8'hff, 1'b0);
		add_request(ACT_PUSH, 8'ha5, 1'b1);
		add_request(ACT_POP, 8'h00, 1'b0);
		add_request(ACT_POP, 8'h00, 1'b0);
		add_request(ACT_POP, 8'h00, 1'b0);
		// fill every slot, then drop while full
		for (int i = 0; i < SLOTS; i++)
			add_request(ACT_PUSH, 8'(8'h10 + i), 1'b1);
		add_request(ACT_PUSH, 8'h3c, 1'b1);
		// frame opened while full stays dropped after a pop
		add_request(ACT_PUSH, 8'h11, 1'b0);
		add_request(ACT_POP, 8'h00, 1'b0);
		add_request(ACT_PUSH, 8'h22, 1'b1);
		add_request(ACT_PUSH, 8'h33, 1'b1);
		add_request(ACT_POP, 8'h00, 1'b0);
		add_request(ACT_PUSH, 8'h44, 1'b1);

		// too long while full, then a maximum frame
		add_frame(MAX_FRAME + 2, 0);
		add_request(ACT_POP, 8'h00, 1'b0);
		add_frame(MAX_FRAME, 0);
		target = pending.size() + RAND_ITEMS;
		while (pending.size() < target) begin
			pop_pct = ((pending.size() / 100) % 2) ? 55 : 20;
			if ($urandom_range(0, 99) < pop_pct)
				add_request(ACT_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			else
				add_frame(pick_length(), 3);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || s_tvalid)
			@(negedge clk);
		while (expected.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);

		if (expected.size() != 0) begin
			$error("%0d expected results never arrived", expected.size());
			errors++;
		end
		$display("ran %0d requests: %0d frames stored, %0d too long, %0d dropped while full",
			n_requests, kind_seen[frq_pkg::KIND_ACCEPT], kind_seen[frq_pkg::KIND_LONG],
			kind_seen[frq_pkg::KIND_DROP]);
		$display("checked %0d results: %0d popped bytes, %0d empty pops",
			n_checked, kind_seen[frq_pkg::KIND_POP_BYTE],
			kind_seen[frq_pkg::KIND_POP_EMPTY]);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
